@@ hw/rtl/gcp_pkg.sv @@
// ---------------------------------------------------------------------------
// gcp_pkg
// shared constants of the coincidence pairer
// ---------------------------------------------------------------------------
package gcp_pkg;
  localparam int MAX_HITS = 16;
  localparam int HC_W     = $clog2(MAX_HITS + 1);
  localparam int ADDR_W   = $clog2(MAX_HITS);
  localparam int TIME_W   = 40;
  localparam int ENTRY_W  = 8 + 16 + TIME_W;
  localparam int DIV_W    = 44;
  localparam int ROOT_W   = 22;

  localparam logic [7:0] REG_WALK_GAIN   = 8'd0;
  localparam logic [7:0] REG_WALK_OFFSET = 8'd1;
  localparam logic [7:0] REG_COINC_WIN   = 8'd2;
  localparam logic [7:0] REG_PROMPT_WIN  = 8'd3;
endpackage

@@ hw/rtl/gcp_ram.sv @@
// ---------------------------------------------------------------------------
// gcp_ram
// generic single-port-write, single-port-read ram with registered read
// ---------------------------------------------------------------------------
module gcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ hw/rtl/gamma_coincidence_pairer.sv @@
// ---------------------------------------------------------------------------
// gamma_coincidence_pairer
// walk-corrects each hit that fits the store and pairs it with the stored hits of its event
// ---------------------------------------------------------------------------
// channel | direction | payload
// in_     | in        | tdata 56b hit, tlast last_hit
// out_    | out       | tdata 136b pair, tuser pair_valid, tlast last
// cfg_    | in        | index 8b, data 16b, always ready
//
// a stored hit goes through accept, a serial divide, a square root, the
// correction, a scan of the stored hits, the store write and the final item.
// a hit arriving at a full store goes straight to the final item.
// reset is synchronous; the hit store needs no clearing.
// a stalled output holds the sequencer; no new item is taken until done.
// ---------------------------------------------------------------------------
module gamma_coincidence_pairer
  import gcp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [55:0]  in_tdata,   // hit_id, energy_raw, hit_time
  input  logic         in_tlast,   // last_hit
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // id_x, id_y, energy_x, energy_y, time_x, time_y,
                                   // prompt, event_end, hits_dropped, zero pad
  output logic         out_tuser,  // pair_valid
  output logic         out_tlast,  // last
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_SQRT = 4'd2;
  localparam logic [3:0] S_CT   = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_CMP  = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_PEND = 4'd7;
  localparam logic [3:0] S_A    = 4'd8;
  localparam logic [3:0] S_WR   = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [15:0] gain_r, offset_r, cwin_r, pwin_r;
  logic [HC_W-1:0] hit_count_r, hit_count_nxt;
  logic [HC_W-1:0] k_r, k_nxt;
  logic ovf_r, ovf_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] div_r, div_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [24:0] srem_r, srem_nxt;
  logic [7:0] id_r, id_nxt;
  logic [15:0] e_r, e_nxt;
  logic [31:0] t_r, t_nxt;
  logic lh_r, lh_nxt;
  logic [TIME_W-1:0] ct_r, ct_nxt;
  logic [TIME_W:0] ad_r, ad_nxt;
  logic pend_v_r, pend_v_nxt;
  logic [7:0] pend_id_r, pend_id_nxt;
  logic [15:0] pend_e_r, pend_e_nxt;
  logic [TIME_W-1:0] pend_t_r, pend_t_nxt;
  logic pend_pr_r, pend_pr_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [135:0] out_data_r, out_data_nxt;
  logic out_user_r, out_user_nxt;
  logic out_last_r, out_last_nxt;

  logic ram_we, ram_re;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [ADDR_W-1:0] ram_raddr;

  logic [7:0] sd_id;
  logic [15:0] sd_e;
  logic [TIME_W-1:0] sd_t;
  logic [15:0] e_div;
  logic [31:0] gain_sq;
  logic [16:0] d_trial;
  logic [25:0] s_trial;
  logic [24:0] s_shift;
  logic [TIME_W:0] diff;
  logic [TIME_W:0] win, pw;
  logic space;
  logic push;
  logic p_valid, p_last, p_end, p_drop, p_pr;
  logic [7:0] p_idx, p_idy;
  logic [15:0] p_ex, p_ey;
  logic [TIME_W-1:0] p_tx, p_ty;

  assign sd_id = ram_rdata[7:0];
  assign sd_e  = ram_rdata[23:8];
  assign sd_t  = ram_rdata[ENTRY_W-1:24];
  assign e_div = (e_r == 16'd0) ? 16'd1 : e_r;
  assign gain_sq = 32'(gain_r) * 32'(gain_r);
  assign d_trial = {rem_r, div_r[DIV_W-1]} - {1'b0, e_div};
  assign s_shift = {srem_r[22:0], div_r[DIV_W-1 -: 2]};
  assign s_trial = {1'b0, s_shift} - {2'b00, root_r, 2'b01};
  assign diff = {sd_t[TIME_W-1], sd_t} - {ct_r[TIME_W-1], ct_r};
  assign win = {{(TIME_W - 19){1'b0}}, cwin_r, 4'b0000};
  assign pw  = {{(TIME_W - 19){1'b0}}, pwin_r, 4'b0000};
  assign space = !out_valid_r || out_tready;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;
  assign out_tlast = out_last_r;

  gcp_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_HITS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hit_count_r[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_wdata = {ct_r, e_r, id_r};
  assign ram_raddr = k_r[ADDR_W-1:0];

  always_comb begin
    state_nxt = state_r;
    hit_count_nxt = hit_count_r;
    k_nxt = k_r;
    ovf_nxt = ovf_r;
    cnt_nxt = cnt_r;
    div_nxt = div_r;
    rem_nxt = rem_r;
    root_nxt = root_r;
    srem_nxt = srem_r;
    id_nxt = id_r;
    e_nxt = e_r;
    t_nxt = t_r;
    lh_nxt = lh_r;
    ct_nxt = ct_r;
    ad_nxt = ad_r;
    pend_v_nxt = pend_v_r;
    pend_id_nxt = pend_id_r;
    pend_e_nxt = pend_e_r;
    pend_t_nxt = pend_t_r;
    pend_pr_nxt = pend_pr_r;
    ram_we = 1'b0;
    ram_re = 1'b0;
    push = 1'b0;
    p_valid = 1'b0;
    p_last = 1'b0;
    p_end = 1'b0;
    p_drop = 1'b0;
    p_pr = 1'b0;
    p_idx = '0;
    p_idy = '0;
    p_ex = '0;
    p_ey = '0;
    p_tx = '0;
    p_ty = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          id_nxt = in_tdata[7:0];
          e_nxt = in_tdata[23:8];
          t_nxt = in_tdata[55:24];
          lh_nxt = in_tlast;
          pend_v_nxt = 1'b0;
          k_nxt = '0;
          if (hit_count_r >= HC_W'(MAX_HITS)) begin
            ovf_nxt = 1'b1;
            state_nxt = S_FIN;
          end else begin
            div_nxt = {gain_sq, 12'd0};
            rem_nxt = '0;
            cnt_nxt = 6'(DIV_W - 1);
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (!d_trial[16]) begin
          rem_nxt = d_trial[15:0];
          div_nxt = {div_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[14:0], div_r[DIV_W-1]};
          div_nxt = {div_r[DIV_W-2:0], 1'b0};
        end
        if (cnt_r == 6'd0) begin
          srem_nxt = '0;
          root_nxt = '0;
          cnt_nxt = 6'(ROOT_W - 1);
          state_nxt = S_SQRT;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      S_SQRT: begin
        div_nxt = {div_r[DIV_W-3:0], 2'b00};
        if (!s_trial[25]) begin
          srem_nxt = s_trial[24:0];
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          srem_nxt = s_shift;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        if (cnt_r == 6'd0) begin
          state_nxt = S_CT;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      S_CT: begin
        ct_nxt = {{(TIME_W - 32){t_r[31]}}, t_r}
               + {{(TIME_W - ROOT_W){1'b0}}, root_r}
               - {{(TIME_W - 20){1'b0}}, offset_r, 4'b0000};
        state_nxt = S_RD;
      end
      S_RD: begin
        if (k_r == hit_count_r) begin
          state_nxt = S_WR;
        end else begin
          ram_re = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        ad_nxt = diff[TIME_W] ? (~diff + 1'b1) : diff;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (ad_r > win) begin
          k_nxt = k_r + 1'b1;
          state_nxt = S_RD;
        end else if (pend_v_r) begin
          state_nxt = S_PEND;
        end else begin
          state_nxt = S_A;
        end
      end
      S_PEND: begin
        p_valid = 1'b1;
        p_idx = id_r;
        p_idy = pend_id_r;
        p_ex = e_r;
        p_ey = pend_e_r;
        p_tx = ct_r;
        p_ty = pend_t_r;
        p_pr = pend_pr_r;
        if (space) begin
          push = 1'b1;
          state_nxt = S_A;
        end
      end
      S_A: begin
        p_valid = 1'b1;
        p_idx = sd_id;
        p_idy = id_r;
        p_ex = sd_e;
        p_ey = e_r;
        p_tx = sd_t;
        p_ty = ct_r;
        p_pr = (ad_r < pw);
        if (space) begin
          push = 1'b1;
          pend_v_nxt = 1'b1;
          pend_id_nxt = sd_id;
          pend_e_nxt = sd_e;
          pend_t_nxt = sd_t;
          pend_pr_nxt = (ad_r < pw);
          k_nxt = k_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_WR: begin
        ram_we = 1'b1;
        hit_count_nxt = hit_count_r + 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        p_last = 1'b1;
        p_end = lh_r;
        p_drop = lh_r & ovf_r;
        if (pend_v_r) begin
          p_valid = 1'b1;
          p_idx = id_r;
          p_idy = pend_id_r;
          p_ex = e_r;
          p_ey = pend_e_r;
          p_tx = ct_r;
          p_ty = pend_t_r;
          p_pr = pend_pr_r;
        end
        if (space || (!pend_v_r && !lh_r)) begin
          push = pend_v_r || lh_r;
          if (lh_r) begin
            hit_count_nxt = '0;
            ovf_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    out_user_nxt = out_user_r;
    out_last_nxt = out_last_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt = {5'd0, p_drop, p_end, p_pr, p_ty, p_tx, p_ey, p_ex, p_idy, p_idx};
      out_user_nxt = p_valid;
      out_last_nxt = p_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hit_count_r <= '0;
      ovf_r <= 1'b0;
      pend_v_r <= 1'b0;
      out_valid_r <= 1'b0;
      gain_r <= 16'd2000;
      offset_r <= 16'd80;
      cwin_r <= 16'd1000;
      pwin_r <= 16'd200;
    end else begin
      state_r <= state_nxt;
      hit_count_r <= hit_count_nxt;
      ovf_r <= ovf_nxt;
      pend_v_r <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        priority case (cfg_index)
          REG_WALK_GAIN:   gain_r <= cfg_data;
          REG_WALK_OFFSET: offset_r <= cfg_data;
          REG_COINC_WIN:   cwin_r <= cfg_data;
          REG_PROMPT_WIN:  pwin_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    cnt_r <= cnt_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    root_r <= root_nxt;
    srem_r <= srem_nxt;
    id_r <= id_nxt;
    e_r <= e_nxt;
    t_r <= t_nxt;
    lh_r <= lh_nxt;
    ct_r <= ct_nxt;
    ad_r <= ad_nxt;
    pend_id_r <= pend_id_nxt;
    pend_e_r <= pend_e_nxt;
    pend_t_r <= pend_t_nxt;
    pend_pr_r <= pend_pr_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end
endmodule
